// ===== rtl/dhpi_pkg.sv =====
`timescale 1ns / 1ps

package dhpi_pkg;

  localparam int unsigned TableSizeDefault = 101;
  localparam int unsigned DigitW = 4;
  localparam int unsigned KeyW = 20;
  localparam int unsigned HashW = 11;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned OutW = 7;
  localparam int unsigned SumW = 32;
  localparam int unsigned FifoDepth = 2;
  localparam logic [DigitW-1:0] KeyLenValid = 4'd6;
  localparam logic [OutW-1:0] OutMax = 7'd127;

  typedef enum logic [1:0] {
    StatusHome      = 2'd0,
    StatusProbed    = 2'd1,
    StatusOverwrite = 2'd2,
    StatusReject    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BackClear,
    BackIdle,
    BackHome,
    BackProbe,
    BackFin
  } back_state_e;

  typedef struct packed {
    logic              rejected;
    logic [DigitW-1:0] stride;
    logic [KeyW-1:0]   key;
  } entry_t;

  function automatic logic [OutW-1:0] sat7(input logic [31:0] v);
    logic [OutW-1:0] r;
    if (v > 32'(OutMax)) begin
      r = OutMax;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/digit_hash_probe_insert_core.sv =====
`timescale 1ns / 1ps

// Inserts six-digit keys into an open-addressed table of TableSize slots and returns one
// result item per input item. After reset the occupancy memory is cleared slot by slot,
// during which in_ready_o stays low. A front pipeline (stages s1, s2, s3) hashes each
// item and feeds a two-entry queue; the back end then takes a rejected key from Idle
// straight to Fin, a key with a free home slot through Home, and one Probe step per probed
// slot, as every probe is one read of the occupancy memory.
module digit_hash_probe_insert_core #(
  parameter int unsigned TableSize = dhpi_pkg::TableSizeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dhpi_pkg::DigitW-1:0]   key_length_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_0_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_1_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_2_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_3_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_4_i,
  input  logic [dhpi_pkg::DigitW-1:0]   digit_5_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [dhpi_pkg::OutW-1:0]     slot_o,
  output logic [dhpi_pkg::OutW-1:0]     collisions_now_o,
  output logic [dhpi_pkg::SumW-1:0]     collision_total_o,
  output logic [dhpi_pkg::OutW-1:0]     stored_count_o
);

  localparam int unsigned IW = $clog2(TableSize);
  localparam int unsigned QW = $bits(dhpi_pkg::entry_t) + IW;

  logic             clearing;
  logic             push, q_ready, q_valid, q_pop;
  dhpi_pkg::entry_t push_entry, pop_entry;
  logic [IW-1:0]    push_home, pop_home;
  logic [QW-1:0]    q_wdata, q_rdata;

  dhpi_front #(
    .TableSize(TableSize)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_length_i(key_length_i),
    .digit_0_i   (digit_0_i),
    .digit_1_i   (digit_1_i),
    .digit_2_i   (digit_2_i),
    .digit_3_i   (digit_3_i),
    .digit_4_i   (digit_4_i),
    .digit_5_i   (digit_5_i),
    .clearing_i  (clearing),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .entry_o     (push_entry),
    .home_o      (push_home)
  );

  assign q_wdata = {push_home, push_entry};

  dhpi_fifo #(
    .Width(QW),
    .Depth(dhpi_pkg::FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign pop_entry = q_rdata[$bits(dhpi_pkg::entry_t)-1:0];
  assign pop_home  = q_rdata[QW-1:$bits(dhpi_pkg::entry_t)];

  dhpi_back #(
    .TableSize(TableSize)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (pop_entry),
    .q_home_i         (pop_home),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .collisions_now_o (collisions_now_o),
    .collision_total_o(collision_total_o),
    .stored_count_o   (stored_count_o)
  );

endmodule

// ===== rtl/dhpi_ram.sv =====
`timescale 1ns / 1ps

module dhpi_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dhpi_front.sv =====
`timescale 1ns / 1ps

module dhpi_front #(
  parameter int unsigned TableSize = dhpi_pkg::TableSizeDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dhpi_pkg::DigitW-1:0]      key_length_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_0_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_1_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_2_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_3_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_4_i,
  input  logic [dhpi_pkg::DigitW-1:0]      digit_5_i,
  input  logic                             clearing_i,
  input  logic                             q_ready_i,
  output logic                             push_o,
  output dhpi_pkg::entry_t                 entry_o,
  output logic [$clog2(TableSize)-1:0]     home_o
);

  localparam int unsigned HW = dhpi_pkg::HashW;
  localparam int unsigned KW = dhpi_pkg::KeyW;
  localparam int unsigned RS = dhpi_pkg::RecipShift;
  localparam int unsigned PrW = HW + RS;
  localparam int unsigned TW = $clog2(TableSize + 1);
  localparam int unsigned IW = $clog2(TableSize);
  localparam int unsigned Recip = (1 << RS) / TableSize;
  localparam logic [HW-1:0] TabH = HW'(TableSize);

  logic             adv;
  logic             accept;
  logic [KW-1:0]    key_c;
  logic [HW-1:0]    hash_c;
  logic [PrW-1:0]   recip_prod;
  logic [HW+TW-1:0] qt_prod;
  logic [HW-1:0]    rem_raw;
  logic [HW-1:0]    rem_fix;

  logic             s1_v_q, s2_v_q, s3_v_q;
  dhpi_pkg::entry_t s1_ent_q, s2_ent_q, s3_ent_q;
  logic [HW-1:0]    s1_hash_q, s2_hash_q, s3_hash_q;
  logic [HW-1:0]    s2_quo_q;
  logic [HW-1:0]    s3_qt_q;

  assign adv        = !s3_v_q || q_ready_i;
  assign in_ready_o = adv && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;

  assign key_c = KW'(digit_0_i) * KW'(100000) + KW'(digit_1_i) * KW'(10000)
               + KW'(digit_2_i) * KW'(1000) + KW'(digit_3_i) * KW'(100)
               + KW'(digit_4_i) * KW'(10) + KW'(digit_5_i);

  assign hash_c = HW'(digit_5_i) * HW'(100) + HW'(digit_1_i) * HW'(10) + HW'(digit_3_i);

  // The quotient estimate is low by at most one, so one subtract corrects it.
  assign recip_prod = PrW'(s1_hash_q) * PrW'(Recip);
  assign qt_prod    = (HW + TW)'(s2_quo_q) * (HW + TW)'(TableSize);
  assign rem_raw    = s3_hash_q - s3_qt_q;
  assign rem_fix    = (rem_raw >= TabH) ? (rem_raw - TabH) : rem_raw;

  assign push_o  = s3_v_q && q_ready_i;
  assign entry_o = s3_ent_q;
  assign home_o  = IW'(rem_fix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ent_q.rejected <= (key_length_i != dhpi_pkg::KeyLenValid);
      s1_ent_q.stride   <= digit_0_i;
      s1_ent_q.key      <= key_c;
      s1_hash_q         <= hash_c;
      s2_ent_q          <= s1_ent_q;
      s2_hash_q         <= s1_hash_q;
      s2_quo_q          <= recip_prod[PrW-1:RS];
      s3_ent_q          <= s2_ent_q;
      s3_hash_q         <= s2_hash_q;
      s3_qt_q           <= qt_prod[HW-1:0];
    end
  end

endmodule

// ===== rtl/dhpi_fifo.sv =====
`timescale 1ns / 1ps

module dhpi_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = dhpi_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/dhpi_back.sv =====
`timescale 1ns / 1ps

module dhpi_back #(
  parameter int unsigned TableSize = dhpi_pkg::TableSizeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  dhpi_pkg::entry_t              q_entry_i,
  input  logic [$clog2(TableSize)-1:0]  q_home_i,
  output logic                          q_pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [dhpi_pkg::OutW-1:0]     slot_o,
  output logic [dhpi_pkg::OutW-1:0]     collisions_now_o,
  output logic [dhpi_pkg::SumW-1:0]     collision_total_o,
  output logic [dhpi_pkg::OutW-1:0]     stored_count_o
);

  localparam int unsigned IW = $clog2(TableSize);
  localparam int unsigned PW = $clog2(TableSize + 16);
  localparam int unsigned NW = $clog2(TableSize + 2);
  localparam int unsigned FW = $clog2(TableSize + 1);
  localparam int unsigned SW = dhpi_pkg::SumW;
  localparam int unsigned OW = dhpi_pkg::OutW;
  localparam logic [PW-1:0] TabP = PW'(TableSize);
  localparam logic [FW-1:0] TabF = FW'(TableSize);
  localparam logic [IW-1:0] LastIdx = IW'(TableSize - 1);

  dhpi_pkg::back_state_e state_q, state_d;
  logic [IW-1:0]         clr_q, clr_d;
  dhpi_pkg::entry_t      ent_q, ent_d;
  logic [IW-1:0]         home_q, home_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [FW-1:0]         probes_q, probes_d;
  logic [NW-1:0]         now_q, now_d;
  dhpi_pkg::status_e     status_q, status_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [SW-1:0]         sum_q, sum_d;

  logic                  out_valid_q, out_valid_d;
  dhpi_pkg::status_e     out_status_q, out_status_d;
  logic [OW-1:0]         out_slot_q, out_slot_d;
  logic [OW-1:0]         out_now_q, out_now_d;
  logic [SW-1:0]         out_total_q, out_total_d;
  logic [OW-1:0]         out_stored_q, out_stored_d;

  logic                  occ_we, occ_re, occ_wdata, occ_rd;
  logic [IW-1:0]         occ_waddr, occ_raddr;
  logic                  key_we;
  logic [IW-1:0]         key_waddr;

  logic [PW-1:0]         pos_base, pos_step;
  logic                  step_out, probe_last, fill_full, out_free;
  logic [SW:0]           sum_ext;
  logic [SW-1:0]         sum_new;

  assign pos_base   = (state_q == dhpi_pkg::BackHome) ? PW'(home_q) : pos_q;
  assign pos_step   = pos_base + PW'(ent_q.stride);
  assign step_out   = (pos_step >= TabP);
  assign probe_last = ((probes_q + FW'(1)) == TabF);
  assign fill_full  = (fill_q >= TabF);
  assign out_free   = !out_valid_q || out_ready_i;
  assign sum_ext    = {1'b0, sum_q} + (SW + 1)'(now_q);
  assign sum_new    = sum_ext[SW] ? '1 : sum_ext[SW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhpi_pkg::BackClear: begin
        if (clr_q == LastIdx) begin
          state_d = dhpi_pkg::BackIdle;
        end
      end
      dhpi_pkg::BackIdle: begin
        if (q_valid_i) begin
          state_d = q_entry_i.rejected ? dhpi_pkg::BackFin : dhpi_pkg::BackHome;
        end
      end
      dhpi_pkg::BackHome: begin
        if (!occ_rd || fill_full || step_out) begin
          state_d = dhpi_pkg::BackFin;
        end else begin
          state_d = dhpi_pkg::BackProbe;
        end
      end
      dhpi_pkg::BackProbe: begin
        if (!occ_rd || probe_last || step_out) begin
          state_d = dhpi_pkg::BackFin;
        end
      end
      dhpi_pkg::BackFin: begin
        if (out_free) begin
          state_d = dhpi_pkg::BackIdle;
        end
      end
      default: state_d = dhpi_pkg::BackIdle;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    ent_d        = ent_q;
    home_d       = home_q;
    pos_d        = pos_q;
    probes_d     = probes_q;
    now_d        = now_q;
    status_d     = status_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_now_d    = out_now_q;
    out_total_d  = out_total_q;
    out_stored_d = out_stored_q;
    occ_we       = 1'b0;
    occ_waddr    = clr_q;
    occ_wdata    = 1'b0;
    occ_re       = 1'b0;
    occ_raddr    = q_home_i;
    key_we       = 1'b0;
    key_waddr    = home_q;
    q_pop_o      = 1'b0;
    clearing_o   = 1'b0;
    unique case (state_q)
      dhpi_pkg::BackClear: begin
        clearing_o = 1'b1;
        occ_we     = 1'b1;
        clr_d      = clr_q + IW'(1);
      end
      dhpi_pkg::BackIdle: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ent_d    = q_entry_i;
          home_d   = q_home_i;
          now_d    = '0;
          probes_d = '0;
          if (q_entry_i.rejected) begin
            status_d = dhpi_pkg::StatusReject;
            slot_d   = '0;
          end else begin
            occ_re = 1'b1;
          end
        end
      end
      dhpi_pkg::BackHome: begin
        if (!occ_rd) begin
          occ_we    = 1'b1;
          occ_waddr = home_q;
          occ_wdata = 1'b1;
          key_we    = 1'b1;
          fill_d    = fill_q + FW'(1);
          status_d  = dhpi_pkg::StatusHome;
          slot_d    = home_q;
        end else begin
          now_d = NW'(1);
          if (fill_full || step_out) begin
            key_we   = 1'b1;
            status_d = dhpi_pkg::StatusOverwrite;
            slot_d   = home_q;
          end else begin
            pos_d     = pos_step;
            occ_re    = 1'b1;
            occ_raddr = IW'(pos_step);
          end
        end
      end
      dhpi_pkg::BackProbe: begin
        if (!occ_rd) begin
          occ_we    = 1'b1;
          occ_waddr = IW'(pos_q);
          occ_wdata = 1'b1;
          key_we    = 1'b1;
          key_waddr = IW'(pos_q);
          fill_d    = fill_q + FW'(1);
          status_d  = dhpi_pkg::StatusProbed;
          slot_d    = IW'(pos_q);
        end else begin
          now_d = now_q + NW'(1);
          if (probe_last || step_out) begin
            key_we   = 1'b1;
            status_d = dhpi_pkg::StatusOverwrite;
            slot_d   = home_q;
          end else begin
            pos_d     = pos_step;
            probes_d  = probes_q + FW'(1);
            occ_re    = 1'b1;
            occ_raddr = IW'(pos_step);
          end
        end
      end
      dhpi_pkg::BackFin: begin
        if (out_free) begin
          sum_d        = sum_new;
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_slot_d   = dhpi_pkg::sat7(32'(slot_q));
          out_now_d    = dhpi_pkg::sat7(32'(now_q));
          out_total_d  = sum_new;
          out_stored_d = dhpi_pkg::sat7(32'(fill_q));
        end
      end
      default: begin
        clearing_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhpi_pkg::BackClear;
      clr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q        <= ent_d;
    home_q       <= home_d;
    pos_q        <= pos_d;
    probes_q     <= probes_d;
    now_q        <= now_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_now_q    <= out_now_d;
    out_total_q  <= out_total_d;
    out_stored_q <= out_stored_d;
  end

  dhpi_ram #(
    .Width(1),
    .Depth(TableSize)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (occ_we),
    .waddr_i(occ_waddr),
    .wdata_i(occ_wdata),
    .re_i   (occ_re),
    .raddr_i(occ_raddr),
    .rdata_o(occ_rd)
  );

  dhpi_ram #(
    .Width(dhpi_pkg::KeyW),
    .Depth(TableSize)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(ent_q.key),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign slot_o            = out_slot_q;
  assign collisions_now_o  = out_now_q;
  assign collision_total_o = out_total_q;
  assign stored_count_o    = out_stored_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TabF)
    else $error("Fill count exceeds the table size.");

  a_occ_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(occ_we && occ_re))
    else $error("Occupancy memory read and written in the same cycle.");

  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q >= $past(sum_q))
    else $error("Collision total decreased.");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dhpi_pkg::BackClear) |-> !q_pop_o)
    else $error("Item taken from the queue during the clearing pass.");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dhpi_pkg::BackFin && out_free) |=> out_valid_q)
    else $error("Finished item did not reach the output register.");

endmodule

// ===== verif/tb_digit_hash_probe_insert_core.sv =====
`timescale 1ns / 1ps

module tb_digit_hash_probe_insert_core;

  localparam int unsigned TableSize = dhpi_pkg::TableSizeDefault;

  typedef enum int unsigned {
    IdleNone,
    IdleAny,
    IdleSparse
  } idle_mode_e;

  typedef struct packed {
    logic [dhpi_pkg::DigitW-1:0]        key_length;
    logic [5:0][dhpi_pkg::DigitW-1:0]   digit;
  } key_item_t;

  typedef struct packed {
    dhpi_pkg::status_e           status;
    logic [dhpi_pkg::OutW-1:0]   slot;
    logic [dhpi_pkg::OutW-1:0]   collisions;
    logic [dhpi_pkg::SumW-1:0]   total;
    logic [dhpi_pkg::OutW-1:0]   count;
  } insert_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready;
  key_item_t                   in_item;
  logic                        out_valid;
  logic                        out_ready;
  logic [1:0]                  status;
  logic [dhpi_pkg::OutW-1:0]   slot;
  logic [dhpi_pkg::OutW-1:0]   collisions_now;
  logic [dhpi_pkg::SumW-1:0]   collision_total;
  logic [dhpi_pkg::OutW-1:0]   stored_count;

  bit                          occupied_slot [TableSize];
  int unsigned                 keys_stored;
  logic [dhpi_pkg::SumW-1:0]   collision_tally;
  insert_result_t              pending_results [$];

  idle_mode_e        send_mode;
  idle_mode_e        recv_mode;
  int unsigned       stall_left;
  int unsigned       hold_off_left;
  int unsigned       results_seen;
  int unsigned       mismatch_count;

  digit_hash_probe_insert_core #(
    .TableSize(TableSize)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .key_length_i      (in_item.key_length),
    .digit_0_i         (in_item.digit[0]),
    .digit_1_i         (in_item.digit[1]),
    .digit_2_i         (in_item.digit[2]),
    .digit_3_i         (in_item.digit[3]),
    .digit_4_i         (in_item.digit[4]),
    .digit_5_i         (in_item.digit[5]),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .slot_o            (slot),
    .collisions_now_o  (collisions_now),
    .collision_total_o (collision_total),
    .stored_count_o    (stored_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [dhpi_pkg::OutW-1:0] clip7(input int unsigned v);
    return (v > 127) ? 7'd127 : v[dhpi_pkg::OutW-1:0];
  endfunction

  function automatic int unsigned draw_wait(input idle_mode_e mode);
    int unsigned n;
    case (mode)
      IdleNone: begin
        n = 0;
      end
      IdleAny: begin
        n = $urandom_range(0, 13);
      end
      default: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      end
    endcase
    return n;
  endfunction

  // Updates the table image for one accepted key and returns the result it causes.
  function automatic insert_result_t insert_key(input key_item_t it);
    insert_result_t r;
    int unsigned home;
    int unsigned pos;
    int unsigned now;
    int unsigned stride;
    bit placed;
    r.status = dhpi_pkg::StatusReject;
    r.slot = '0;
    r.collisions = '0;
    now = 0;
    placed = 1'b0;
    if (it.key_length == dhpi_pkg::KeyLenValid) begin
      home = (int'(it.digit[5]) * 100 + int'(it.digit[1]) * 10 + int'(it.digit[3])) % TableSize;
      stride = it.digit[0];
      if (!occupied_slot[home]) begin
        occupied_slot[home] = 1'b1;
        keys_stored++;
        r.status = dhpi_pkg::StatusHome;
        r.slot = clip7(home);
      end else if (keys_stored >= TableSize) begin
        now = 1;
        r.status = dhpi_pkg::StatusOverwrite;
        r.slot = clip7(home);
      end else begin
        now = 1;
        pos = home;
        for (int i = 0; i < TableSize; i++) begin
          pos += stride;
          if (pos >= TableSize) break;
          if (!occupied_slot[pos]) begin
            occupied_slot[pos] = 1'b1;
            keys_stored++;
            placed = 1'b1;
            break;
          end
          now++;
        end
        r.status = placed ? dhpi_pkg::StatusProbed : dhpi_pkg::StatusOverwrite;
        r.slot = clip7(placed ? pos : home);
      end
      if (now > 32'hFFFF_FFFF - collision_tally) begin
        collision_tally = 32'hFFFF_FFFF;
      end else begin
        collision_tally = collision_tally + now;
      end
    end
    r.collisions = clip7(now);
    r.total = collision_tally;
    r.count = clip7(keys_stored);
    return r;
  endfunction

  function automatic key_item_t mk_key(input int unsigned len, input int unsigned d0,
                                       input int unsigned d1, input int unsigned d2,
                                       input int unsigned d3, input int unsigned d4,
                                       input int unsigned d5);
    key_item_t r;
    r.key_length = len[dhpi_pkg::DigitW-1:0];
    r.digit[0] = d0[dhpi_pkg::DigitW-1:0];
    r.digit[1] = d1[dhpi_pkg::DigitW-1:0];
    r.digit[2] = d2[dhpi_pkg::DigitW-1:0];
    r.digit[3] = d3[dhpi_pkg::DigitW-1:0];
    r.digit[4] = d4[dhpi_pkg::DigitW-1:0];
    r.digit[5] = d5[dhpi_pkg::DigitW-1:0];
    return r;
  endfunction

  function automatic key_item_t random_key();
    key_item_t r;
    r.key_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : dhpi_pkg::KeyLenValid;
    for (int k = 0; k < 6; k++) begin
      r.digit[k] = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
    end
    if ($urandom_range(0, 2) == 0) begin
      r.digit[0] = 4'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic send_key(input key_item_t it);
    int unsigned gap;
    gap = draw_wait(send_mode);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(insert_key(it));
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [dhpi_pkg::SumW-1:0] exp_v,
                                 input logic [dhpi_pkg::SumW-1:0] got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    mismatch_count++;
  endtask

  // The ready line is driven here alone, one cycle at a time.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left != 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    insert_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no pending item, status %0d slot %0d", $time,
                   status, slot);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status) report_mismatch("status", exp_r.status, status);
          if (slot !== exp_r.slot) report_mismatch("slot", exp_r.slot, slot);
          if (collisions_now !== exp_r.collisions) begin
            report_mismatch("collisions_now", exp_r.collisions, collisions_now);
          end
          if (collision_total !== exp_r.total) begin
            report_mismatch("collision_total", exp_r.total, collision_total);
          end
          if (stored_count !== exp_r.count) begin
            report_mismatch("stored_count", exp_r.count, stored_count);
          end
        end
        results_seen++;
        if (results_seen % 64 == 0) recv_mode = idle_mode_e'($urandom_range(0, 2));
        stall_left = draw_wait(recv_mode);
      end
    end
  end

  task automatic test_directed_cases();
    send_mode = IdleAny;
    send_key(mk_key(0, 0, 0, 0, 0, 0, 0));
    send_key(mk_key(15, 15, 15, 15, 15, 15, 15));
    send_key(mk_key(5, 1, 2, 3, 4, 5, 6));
    send_key(mk_key(7, 9, 8, 7, 6, 5, 4));
    send_key(mk_key(6, 0, 0, 0, 0, 0, 0));
    send_key(mk_key(6, 0, 0, 0, 0, 0, 0));
    send_key(mk_key(6, 1, 0, 5, 0, 10, 0));
    send_key(mk_key(6, 1, 0, 10, 0, 5, 0));
    send_key(mk_key(6, 9, 9, 0, 9, 0, 0));
    send_key(mk_key(6, 9, 9, 1, 9, 1, 0));
    send_key(mk_key(6, 1, 0, 0, 0, 0, 1));
    send_key(mk_key(6, 1, 0, 2, 0, 2, 1));
    send_key(mk_key(6, 15, 15, 15, 15, 15, 15));
    send_key(mk_key(6, 15, 15, 0, 15, 0, 15));
    send_key(mk_key(6, 10, 15, 3, 15, 3, 15));
    send_key(mk_key(6, 3, 9, 3, 9, 3, 9));
    send_key(mk_key(6, 15, 9, 4, 9, 4, 9));
    send_key(mk_key(6, 5, 9, 5, 9, 5, 9));
    send_key(mk_key(6, 5, 9, 6, 9, 6, 9));
    send_key(mk_key(6, 0, 15, 7, 15, 7, 15));
  endtask

  task automatic test_random_probing();
    for (int n = 0; n < 650; n++) begin
      if (n % 50 == 0) send_mode = idle_mode_e'($urandom_range(0, 2));
      send_key(random_key());
    end
  endtask

  // A long hold on the result side fills the internal queue and stalls the input.
  task automatic test_backpressure_fill();
    pause_until_drained();
    send_mode = IdleNone;
    hold_off_left = 300;
    for (int n = 0; n < 30; n++) begin
      send_key(random_key());
    end
  endtask

  task automatic test_fill_every_slot();
    key_item_t it;
    send_mode = IdleSparse;
    for (int unsigned t = 0; t < TableSize; t++) begin
      if (!occupied_slot[t]) begin
        it = random_key();
        it.key_length = dhpi_pkg::KeyLenValid;
        it.digit[5] = (t == 100) ? 4'd1 : 4'd0;
        it.digit[1] = (t == 100) ? 4'd0 : 4'(t / 10);
        it.digit[3] = (t == 100) ? 4'd0 : 4'(t % 10);
        send_key(it);
      end
    end
  endtask

  task automatic test_full_table_overwrites();
    for (int n = 0; n < 400; n++) begin
      if (n % 40 == 0) send_mode = idle_mode_e'($urandom_range(0, 2));
      send_key(random_key());
    end
  endtask

  task automatic test_drain_between_bursts();
    for (int b = 0; b < 5; b++) begin
      pause_until_drained();
      send_mode = idle_mode_e'(b % 3);
      for (int n = 0; n < 20; n++) begin
        send_key(random_key());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    occupied_slot = '{default: 1'b0};
    keys_stored = 0;
    collision_tally = '0;
    send_mode = IdleAny;
    recv_mode = IdleAny;
    stall_left = 0;
    hold_off_left = 0;
    results_seen = 0;
    mismatch_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_probing();
    test_backpressure_fill();
    test_fill_every_slot();
    test_full_table_overwrites();
    test_drain_between_bursts();

    pause_until_drained();
    repeat (TableSize + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
